[rtl/core/chd_pkg.sv]
// Package for the canonical Huffman decoder core: stream field layout,
// register indexes, controller state encoding and control/status structs.
// No dependencies.
package chd_pkg;

	localparam int INDEX_W    = 8;
	localparam int CODE_W     = 16;
	localparam int LENGTH_W   = 5;
	localparam int SYMBOL_W   = 8;
	localparam int DBYTE_W    = 8;
	localparam int DBITS_W    = 4;
	localparam int WORD_W     = 32;

	localparam int OFS_INDEX  = 0;
	localparam int OFS_CODE   = OFS_INDEX + INDEX_W;
	localparam int OFS_LENGTH = OFS_CODE + CODE_W;
	localparam int OFS_SYMBOL = OFS_LENGTH + LENGTH_W;
	localparam int OFS_DBYTE  = OFS_SYMBOL + SYMBOL_W;
	localparam int OFS_DBITS  = OFS_DBYTE + DBYTE_W;
	localparam int IN_TDATA_W = 56;
	localparam int OUT_TDATA_W = SYMBOL_W;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 9;
	localparam int MCL_CFG_W   = 5;
	localparam int ENT_CFG_W   = 9;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_DATA = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_CODE_LENGTH = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TABLE_ENTRIES   = 1'd1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic take_item;
		logic start_scan;
		logic scan;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic item_is_data;
		logic decode_due;
		logic hit;
		logic exhausted;
		logic out_free;
	} dp_status_t;

endpackage

[rtl/core/chd_controller.sv]
// Sequencer of the canonical Huffman decoder core: takes words, starts
// table scans and hands decoded results to the output register.
// Depends on chd_pkg.
module chd_controller import chd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && status.item_is_data) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = status.decode_due ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				if (status.hit || status.exhausted) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					state_d = ST_CHECK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready       = (state_q == ST_IDLE);
	assign cmd.take_item  = s_tvalid && (state_q == ST_IDLE);
	assign cmd.start_scan = (state_q == ST_CHECK) && status.decode_due;
	assign cmd.scan       = (state_q == ST_SCAN);
	assign cmd.emit       = (state_q == ST_EMIT) && status.out_free;

endmodule

[rtl/core/chd_datapath.sv]
// Datapath of the canonical Huffman decoder core: code table memory, bit
// buffer, window builder, scan compare, configuration and output register.
// Depends on chd_pkg.
module chd_datapath import chd_pkg::*; #(
	parameter int TABLE_DEPTH = 256,
	parameter int MAX_LEN     = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tuser,
	input  logic                   s_tlast,
	input  dp_cmd_t                cmd,
	output dp_status_t             status,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int ENT_W     = $clog2(TABLE_DEPTH + 1);
	localparam int BUF_W     = MAX_LEN + 8;
	localparam int CNT_W     = $clog2(BUF_W + 1);
	localparam int LEN_W     = $clog2(MAX_LEN + 1);
	localparam int ENT_XW    = (ENT_W > ENT_CFG_W) ? ENT_W : ENT_CFG_W;
	localparam int MCL_XW    = (LEN_W > MCL_CFG_W) ? LEN_W : MCL_CFG_W;
	localparam int CW        = (CNT_W > LENGTH_W) ? CNT_W : LENGTH_W;
	localparam int TW        = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int ENTRY_W   = CODE_W + LENGTH_W + SYMBOL_W;
	localparam int MCL_RESET = (MAX_LEN < 16) ? MAX_LEN : 16;
	localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

	function automatic logic [IDX_W-1:0] slot_of(input logic [INDEX_W-1:0] idx);
		logic [INDEX_W:0] v;
		v = {1'b0, idx};
		for (int k = INDEX_W - 1; k >= 0; k--) begin
			if ((TABLE_DEPTH << k) < (1 << INDEX_W)) begin
				if (v >= (INDEX_W + 1)'(TABLE_DEPTH << k)) begin
					v = v - (INDEX_W + 1)'(TABLE_DEPTH << k);
				end
			end
		end
		return IDX_W'(v);
	endfunction

	logic [INDEX_W-1:0]  f_index;
	logic [CODE_W-1:0]   f_code;
	logic [LENGTH_W-1:0] f_length;
	logic [SYMBOL_W-1:0] f_symbol;
	logic [DBYTE_W-1:0]  f_dbyte;
	logic [DBITS_W-1:0]  f_dbits;

	assign f_index  = s_tdata[OFS_INDEX +: INDEX_W];
	assign f_code   = s_tdata[OFS_CODE +: CODE_W];
	assign f_length = s_tdata[OFS_LENGTH +: LENGTH_W];
	assign f_symbol = s_tdata[OFS_SYMBOL +: SYMBOL_W];
	assign f_dbyte  = s_tdata[OFS_DBYTE +: DBYTE_W];
	assign f_dbits  = s_tdata[OFS_DBITS +: DBITS_W];

	logic [LEN_W-1:0]  mcl_q;
	logic [ENT_W-1:0]  entries_q;
	logic [MCL_XW-1:0] mcl_wr;
	logic [ENT_XW-1:0] ent_wr;

	always_comb begin
		mcl_wr = MCL_XW'(cfg_data[MCL_CFG_W-1:0]);
		if (mcl_wr == '0) begin
			mcl_wr = MCL_XW'(1);
		end else if (mcl_wr > MCL_XW'(MAX_LEN)) begin
			mcl_wr = MCL_XW'(MAX_LEN);
		end
		ent_wr = ENT_XW'(cfg_data[ENT_CFG_W-1:0]);
		if (ent_wr > ENT_XW'(TABLE_DEPTH)) begin
			ent_wr = ENT_XW'(TABLE_DEPTH);
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcl_q     <= LEN_W'(MCL_RESET);
			entries_q <= ENT_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAX_CODE_LENGTH: mcl_q     <= LEN_W'(mcl_wr);
				REG_TABLE_ENTRIES:   entries_q <= ENT_W'(ent_wr);
			endcase
		end
	end

	logic [BUF_W-1:0] buffer_q;
	logic [CNT_W-1:0] count_q;
	logic             eos_q;
	logic [DBITS_W-1:0] push_n;
	logic [DBYTE_W-1:0] push_bits;
	logic [BUF_W-1:0] buf_push;
	logic [CNT_W-1:0] count_push;

	always_comb begin
		push_n = (f_dbits > DBITS_W'(DBYTE_W)) ? DBITS_W'(DBYTE_W) : f_dbits;
		push_bits = f_dbyte >> (DBITS_W'(DBYTE_W) - push_n);
		buf_push = (buffer_q << push_n) | BUF_W'(push_bits);
		count_push = count_q + CNT_W'(push_n);
	end

	logic [TW-1:0]           take;
	logic [BUF_W+WORD_W-1:0] aligned;
	logic [WORD_W-1:0]       lead;
	logic [WORD_W-1:0]       window;
	logic [WORD_W-1:0]       window_q;

	always_comb begin
		take = (TW'(count_q) < TW'(mcl_q)) ? TW'(count_q) : TW'(mcl_q);
		aligned = {buffer_q, WORD_W'(0)} << (CNT_W'(BUF_W) - count_q);
		lead = aligned[BUF_W+WORD_W-1 -: WORD_W];
		window = (lead & ~(ONES >> take)) | (ONES >> mcl_q);
	end

	logic [ENTRY_W-1:0] table_mem_q [TABLE_DEPTH];
	logic [ENTRY_W-1:0] rd_s1;
	logic               valid_s1;
	logic [ENT_W-1:0]   issue_idx_q;
	logic               issue;

	assign issue = cmd.scan && (issue_idx_q != entries_q);

	always_ff @(posedge clk) begin
		if (cmd.take_item && s_tuser == MODE_LOAD) begin
			table_mem_q[slot_of(f_index)] <= {f_code, f_length, f_symbol};
		end
		if (issue) begin
			rd_s1 <= table_mem_q[issue_idx_q[IDX_W-1:0]];
		end
	end

	logic [CODE_W-1:0]   rd_code;
	logic [LENGTH_W-1:0] rd_len;
	logic [SYMBOL_W-1:0] rd_sym;
	logic [WORD_W-1:0]   key;
	logic                hit;

	assign rd_code = rd_s1[ENTRY_W-1 -: CODE_W];
	assign rd_len  = rd_s1[SYMBOL_W +: LENGTH_W];
	assign rd_sym  = rd_s1[SYMBOL_W-1:0];
	assign key     = {rd_code, (WORD_W - CODE_W)'(0)} | (ONES >> rd_len);
	assign hit     = valid_s1 && (key >= window_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			issue_idx_q <= '0;
		end else if (cmd.start_scan) begin
			valid_s1    <= 1'b0;
			issue_idx_q <= '0;
		end else if (cmd.scan) begin
			valid_s1 <= issue;
			if (issue) begin
				issue_idx_q <= issue_idx_q + ENT_W'(1);
			end
		end
	end

	logic [SYMBOL_W-1:0] res_sym_q;
	logic [LENGTH_W-1:0] res_len_q;
	logic                res_miss_q;

	always_ff @(posedge clk) begin
		if (cmd.start_scan) begin
			window_q <= window;
		end
		if (cmd.scan) begin
			res_sym_q  <= rd_sym;
			res_len_q  <= rd_len;
			res_miss_q <= !hit;
		end
	end

	logic [CW-1:0]    drop;
	logic [CNT_W-1:0] new_count;
	logic [BUF_W-1:0] keep_mask;

	always_comb begin
		drop = CW'(res_len_q);
		if (drop > CW'(count_q)) begin
			drop = CW'(count_q);
		end
		if (drop == '0) begin
			drop = CW'(1);
		end
		new_count = count_q - CNT_W'(drop);
		keep_mask = ~({BUF_W{1'b1}} << new_count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_q <= '0;
			count_q  <= '0;
			eos_q    <= 1'b0;
		end else if (cmd.take_item && s_tuser == MODE_DATA) begin
			buffer_q <= buf_push;
			count_q  <= count_push;
			eos_q    <= s_tlast;
		end else if (cmd.emit) begin
			if (res_miss_q) begin
				buffer_q <= '0;
				count_q  <= '0;
			end else begin
				buffer_q <= buffer_q & keep_mask;
				count_q  <= new_count;
			end
		end
	end

	logic                m_valid_q;
	logic [SYMBOL_W-1:0] out_sym_q;
	logic                out_miss_q;
	logic                out_last_q;
	logic                out_free;

	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_sym_q  <= res_miss_q ? '0 : res_sym_q;
			out_miss_q <= res_miss_q;
			out_last_q <= eos_q && (res_miss_q || new_count == '0);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_sym_q;
	assign m_tuser  = out_miss_q;
	assign m_tlast  = out_last_q;

	assign status.item_is_data = (s_tuser == MODE_DATA);
	assign status.decode_due   = (count_q != '0) && ((TW'(count_q) >= TW'(mcl_q)) || eos_q);
	assign status.hit          = hit;
	assign status.exhausted    = !hit && (issue_idx_q == entries_q);
	assign status.out_free     = out_free;

endmodule

[rtl/core/canonical_huffman_decoder_core.sv]
// Canonical Huffman decoder core, top level.
// Joins chd_controller and chd_datapath; depends on chd_pkg.
//
// Input words on s_*: s_tuser selects the kind. A table word (s_tuser low)
// writes one entry (code left-aligned, length, symbol) into the slot given
// by its index; the user must load entries in ascending canonical order
// (not enforced by the block). A data word (s_tuser high) appends 0 to 8 bits,
// first bit at data_byte bit 7; s_tlast ends the stream and flushes all bits.
// Output words on m_*: the decoded symbol in m_tdata, m_tuser high when no
// entry matched (the bit buffer is then dropped), m_tlast on the last word
// caused by an end-of-stream word.
// Configuration writes (index 0: longest code length, index 1: number of
// entries) are taken every cycle; the user must write them only while no
// decode is in progress, which the block itself does not enforce.
// Each decoded symbol costs a linear scan through the table memory, one entry
// per cycle through its registered read port.
// One input word is processed at a time; s_tready is low while decoding.
// A finished symbol waits in the output register; if m_tready stays low,
// the next symbol is decoded but held until the waiting one is taken.
// Reset empties the bit buffer and sets the registers to min(MAX_LEN, 16)
// and 1; table contents are undefined until loaded.
module canonical_huffman_decoder_core import chd_pkg::*; #(
	parameter int TABLE_DEPTH = 256,
	parameter int MAX_LEN     = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// entry_index, entry_code, entry_length, entry_symbol, data_byte,
	// data_bits, then zero fill.
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// mode.
	input  logic                   s_tuser,
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// symbol.
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// no_match.
	output logic                   m_tuser,
	output logic                   m_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	chd_controller u_controller (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	chd_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_LEN     (MAX_LEN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.cmd       (cmd),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
